FILE: rtl/core/tprt_pkg.sv
// ----------------------------------------------------------------------------
// tprt_pkg: shared types and constants of the timed pair relation table
// Sizes, operation and status codes, and the cell entry and control words.
// ----------------------------------------------------------------------------
package tprt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ABSENT    = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_REFRESHED = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_FULL      = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_DONE      = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0] first;
    logic [ID_BITS-1:0] second;
    logic [TIME_W-1:0]  time_left;
    logic               flag;
  } entry_t;

  typedef struct packed {
    logic [ID_BITS-1:0] a;
    logic [ID_BITS-1:0] b;
    logic [TIME_W-1:0]  value;
    logic               refresh;
    logic               append;
    logic               shift_hit;
    logic               mark;
    logic               shift_flag;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/tprt_cell.sv
// ----------------------------------------------------------------------------
// tprt_cell: one entry of the pair table
// Holds one pair with its timer and expiry flag, compares it against the
// command word and takes its neighbour's entry when the row closes a gap.
// ----------------------------------------------------------------------------
module tprt_cell
  import tprt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       tail_i,
  input  entry_t     nb_i,
  input  logic       chain_i,
  output entry_t     entry_o,
  output logic       hit_o,
  output logic       chain_o,
  output logic       pick_o
);

  logic [ID_BITS-1:0] first_q, first_d;
  logic [ID_BITS-1:0] second_q, second_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic               flag_q, flag_d;
  logic               hit, sel, shift, expire;

  always_comb begin
    hit = occ_i && ((first_q == ctrl_i.a && second_q == ctrl_i.b) ||
                    (first_q == ctrl_i.b && second_q == ctrl_i.a));
    sel    = (ctrl_i.shift_hit && hit) || (ctrl_i.shift_flag && occ_i && flag_q);
    shift  = chain_i || sel;
    expire = time_q <= ctrl_i.value;
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    time_d   = time_q;
    flag_d   = flag_q;
    priority if (shift) begin
      // close the gap: take the entry from the younger neighbour
      first_d  = nb_i.first;
      second_d = nb_i.second;
      time_d   = nb_i.time_left;
      flag_d   = nb_i.flag;
    end else if (ctrl_i.mark && occ_i) begin
      flag_d = expire;
      if (!expire) begin
        time_d = time_q - ctrl_i.value;
      end
    end else if (ctrl_i.refresh && hit) begin
      time_d = ctrl_i.value;
    end else if (ctrl_i.append && tail_i) begin
      first_d  = ctrl_i.a;
      second_d = ctrl_i.b;
      time_d   = ctrl_i.value;
      flag_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    time_q   <= time_d;
  end

  assign entry_o = '{first: first_q, second: second_q, time_left: time_q, flag: flag_q};
  assign hit_o   = hit;
  assign chain_o = shift;
  assign pick_o  = sel && !chain_i;

endmodule

FILE: rtl/core/timed_pair_relation_table_unit.sv
// ----------------------------------------------------------------------------
// timed_pair_relation_table_unit: insertion-ordered table of timed id pairs
// Query, add/refresh, remove and tick over a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with operation_i and its operands; the word is taken at the
//   edge where start is high and busy is low. Results leave on status_o,
//   expired_first_o, expired_second_o and last_o, each valid for exactly one
//   cycle while result_valid_o is high; last_o marks the final result of a
//   command. The receiver cannot stall the block.
//   Query, add and remove give their result in the cycle after acceptance
//   and busy stays low, so one command per cycle is taken.
//   A tick marks expired entries at acceptance, then drains them oldest
//   first, one per cycle, through the shift of the cell row; busy stays
//   high through the drain, which gives one expired word per expired entry
//   (at most TABLE_DEPTH) and then the done word. Results are registered
//   and follow each drain step in the cycle after it.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_pair_relation_table_unit
  import tprt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [ID_BITS-1:0] first_faction_i,
  input  logic [ID_BITS-1:0] second_faction_i,
  input  logic [TIME_W-1:0]  duration_i,
  input  logic [TIME_W-1:0]  elapsed_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic [ID_BITS-1:0] expired_first_o,
  output logic [ID_BITS-1:0] expired_second_o,
  output logic               last_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               res_valid_q, res_valid_d;
  status_e            res_status_q, res_status_d;
  logic [ID_BITS-1:0] res_first_q, res_first_d;
  logic [ID_BITS-1:0] res_second_q, res_second_d;
  logic               res_last_q, res_last_d;

  cell_ctrl_t             ctrl;
  op_e                    op;
  logic                   accept, any_hit, full, chain_end;
  logic [TABLE_DEPTH-1:0] occ, tail, hit_vec, pick_vec;
  logic [TABLE_DEPTH:0]   chain;
  entry_t                 entries [TABLE_DEPTH];
  logic [ID_BITS-1:0]     pick_first, pick_second;

  assign op        = op_e'(operation_i);
  assign busy      = (state_q == S_DRAIN);
  assign accept    = start && !busy;
  assign any_hit   = |hit_vec;
  assign full      = (count_q == CNT_W'(TABLE_DEPTH));
  assign chain[0]  = 1'b0;
  assign chain_end = chain[TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t nb;
    assign occ[i]  = CNT_W'(i) < count_q;
    assign tail[i] = CNT_W'(i) == count_q;
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = entries[i+1];
    end
    tprt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .occ_i   (occ[i]),
      .tail_i  (tail[i]),
      .nb_i    (nb),
      .chain_i (chain[i]),
      .entry_o (entries[i]),
      .hit_o   (hit_vec[i]),
      .chain_o (chain[i+1]),
      .pick_o  (pick_vec[i])
    );
  end

  // oldest flagged entry, one-hot select
  always_comb begin
    pick_first  = '0;
    pick_second = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pick_first  = pick_first  | ({ID_BITS{pick_vec[i]}} & entries[i].first);
      pick_second = pick_second | ({ID_BITS{pick_vec[i]}} & entries[i].second);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op == OP_TICK) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!chain_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.a       = first_faction_i;
    ctrl.b       = second_faction_i;
    ctrl.value   = (op == OP_TICK) ? elapsed_i : duration_i;
    count_d      = count_q;
    res_valid_d  = 1'b0;
    res_status_d = ST_ABSENT;
    res_first_d  = '0;
    res_second_d = '0;
    res_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          unique case (op)
            OP_QUERY: begin
              res_status_d = any_hit ? ST_PRESENT : ST_ABSENT;
            end
            OP_ADD: begin
              ctrl.refresh = 1'b1;
              if (any_hit) begin
                res_status_d = ST_REFRESHED;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                ctrl.append  = 1'b1;
                res_status_d = ST_INSERTED;
                count_d      = count_q + 1'b1;
              end
            end
            OP_REMOVE: begin
              ctrl.shift_hit = 1'b1;
              if (any_hit) begin
                res_status_d = ST_PRESENT;
                count_d      = count_q - 1'b1;
              end
            end
            OP_TICK: begin
              // mark and count down now, emit during the drain
              ctrl.mark   = 1'b1;
              res_valid_d = 1'b0;
            end
            default: res_valid_d = 1'b0;
          endcase
        end
      end
      S_DRAIN: begin
        ctrl.shift_flag = 1'b1;
        res_valid_d     = 1'b1;
        if (chain_end) begin
          res_status_d = ST_EXPIRED;
          res_first_d  = pick_first;
          res_second_d = pick_second;
          res_last_d   = 1'b0;
          count_d      = count_q - 1'b1;
        end else begin
          res_status_d = ST_DONE;
        end
      end
      default: res_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_status_q;
  assign expired_first_o  = res_first_q;
  assign expired_second_o = res_second_q;
  assign last_o           = res_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_unique_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("pair stored in more than one cell");

  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pick_vec))
    else $error("more than one cell picked for the drain");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i != OP_TICK) |=> (result_valid_o && last_o))
    else $error("single-result command gave no closing word");

  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_EXPIRED) |-> (!last_o && busy) ||
    (!last_o && $past(busy)))
    else $error("expired word flagged as last");

endmodule
